FILE: rtl/pngcsv_pkg.sv
package pngcsv_pkg;

    typedef enum logic [4:0] {
        PH_SIG  = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CRC  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        V_INVALID   = 2'd0,
        V_PROMISING = 2'd1,
        V_VALIDATES = 2'd2
    } verdict_t;

    typedef struct packed {
        logic        fire;
        verdict_t    verdict;
        logic [31:0] size;
    } result_t;

    localparam int          SIG_LEN      = 8;
    localparam logic [31:0] FIELD_BYTES  = 32'd4;
    localparam logic [31:0] FIRST_START  = 32'd8;
    localparam logic [31:0] IHDR_LEN     = 32'd13;
    localparam logic [31:0] TYPE_IHDR    = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND    = 32'h4945_4E44;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET   = 32'hFFFF_FFFF;
    localparam int          TDATA_W      = 40;

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

FILE: rtl/png_chunk_stream_validator.sv
// Channel  Dir  Beat contents (low bit first)             Beats
// s_       in   tdata[7:0] data_byte; tlast last_byte     one per file byte
// m_       out  tdata[1:0] verdict, [33:2] covered_bytes  zero or one per byte
//
// One byte per cycle while s_tready is high; the next parse state and CRC-32 are computed
// combinationally, and the result is registered in the cycle after the byte that decides it.
// aresetn is synchronous, active low; it rearms the parser for a new file.
// A result held while m_tready is low stalls the input;
// s_tready = !m_tvalid || m_tready.
module png_chunk_stream_validator
    import pngcsv_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [1:0] verdict, [33:2] covered_bytes
);

    logic                m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                s_fire;
    result_t             res;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    pngcsv_parser #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .result  (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res.fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, res.size, res.verdict};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_invalid_size_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == V_INVALID |-> m_tdata[33:2] == 32'd0)
        else $error("invalid verdict with nonzero size");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == V_INVALID || m_tdata[1:0] == V_PROMISING ||
                      m_tdata[1:0] == V_VALIDATES))
        else $error("undefined verdict code");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res.fire |=> m_tvalid)
        else $error("result lost");

    a_no_fire_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |-> !res.fire)
        else $error("result without input beat");

endmodule

FILE: rtl/pngcsv_parser.sv
module pngcsv_parser
    import pngcsv_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output result_t       result
);

    localparam logic [OFFSET_WIDTH-1:0] START_INIT = OFFSET_WIDTH'(FIRST_START);

    logic [OFFSET_WIDTH-1:0] byte_offset_reg, byte_offset_next;
    phase_t                  phase_reg, phase_next;
    logic [31:0]             field_count_reg, field_count_next;
    logic [31:0]             chunk_length_reg, chunk_length_next;
    logic [31:0]             chunk_type_reg, chunk_type_next;
    logic [OFFSET_WIDTH-1:0] chunk_start_reg, chunk_start_next;
    logic [31:0]             crc_accum_reg, crc_accum_next;
    logic [31:0]             stored_check_reg, stored_check_next;
    logic                    header_seen_reg, header_seen_next;
    logic                    done_reg, done_next;

    logic [OFFSET_WIDTH-1:0] off_inc;
    logic [31:0]             fc_inc;
    logic [31:0]             fc_dec;
    logic [31:0]             crc_upd;

    assign off_inc = (byte_offset_reg == '1) ? byte_offset_reg : byte_offset_reg + 1'b1;
    assign fc_inc  = field_count_reg + 32'd1;
    assign fc_dec  = (field_count_reg != 32'd0) ? field_count_reg - 32'd1 : 32'd0;
    assign crc_upd = crc32_byte(crc_accum_reg, in_byte);

    always_comb begin
        byte_offset_next  = off_inc;
        phase_next        = phase_reg;
        field_count_next  = field_count_reg;
        chunk_length_next = chunk_length_reg;
        chunk_type_next   = chunk_type_reg;
        chunk_start_next  = chunk_start_reg;
        crc_accum_next    = crc_accum_reg;
        stored_check_next = stored_check_reg;
        header_seen_next  = header_seen_reg;
        done_next         = done_reg;
        result            = '{fire: 1'b0, verdict: V_INVALID, size: 32'd0};

        if (!done_reg) begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (field_count_reg >= 32'(SIG_LEN) ||
                        in_byte != SIG_BYTES[field_count_reg[2:0]]) begin
                        result    = '{fire: 1'b1, verdict: V_INVALID, size: 32'd0};
                        done_next = 1'b1;
                    end else if (fc_inc == 32'(SIG_LEN)) begin
                        phase_next       = PH_LEN;
                        field_count_next = 32'd0;
                        chunk_start_next = off_inc;
                    end else begin
                        field_count_next = fc_inc;
                    end
                end
                PH_LEN: begin
                    chunk_length_next = {chunk_length_reg[23:0], in_byte};
                    if (fc_inc >= FIELD_BYTES) begin
                        phase_next       = PH_TYPE;
                        field_count_next = 32'd0;
                        crc_accum_next   = CRC_PRESET;
                        chunk_type_next  = 32'd0;
                    end else begin
                        field_count_next = fc_inc;
                    end
                end
                PH_TYPE: begin
                    chunk_type_next = {chunk_type_reg[23:0], in_byte};
                    crc_accum_next  = crc_upd;
                    if (fc_inc >= FIELD_BYTES) begin
                        stored_check_next = 32'd0;
                        if (chunk_length_reg != 32'd0) begin
                            phase_next       = PH_DATA;
                            field_count_next = chunk_length_reg;
                        end else begin
                            phase_next       = PH_CRC;
                            field_count_next = 32'd0;
                        end
                    end else begin
                        field_count_next = fc_inc;
                    end
                end
                PH_DATA: begin
                    crc_accum_next   = crc_upd;
                    field_count_next = fc_dec;
                    if (fc_dec == 32'd0) begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC: begin
                    stored_check_next = {stored_check_reg[23:0], in_byte};
                    if (fc_inc >= FIELD_BYTES) begin
                        if (~crc_accum_reg != stored_check_next) begin
                            result    = '{fire: 1'b1, verdict: V_INVALID, size: 32'd0};
                            done_next = 1'b1;
                        end else if (chunk_type_reg == TYPE_IHDR) begin
                            if (chunk_start_reg != START_INIT || chunk_length_reg != IHDR_LEN) begin
                                result    = '{fire: 1'b1, verdict: V_INVALID, size: 32'd0};
                                done_next = 1'b1;
                            end else begin
                                header_seen_next = 1'b1;
                            end
                        end else if (chunk_type_reg == TYPE_IEND) begin
                            done_next = 1'b1;
                            if (header_seen_reg) begin
                                result = '{fire: 1'b1, verdict: V_VALIDATES,
                                           size: sat32(64'(off_inc))};
                            end else begin
                                result = '{fire: 1'b1, verdict: V_INVALID, size: 32'd0};
                            end
                        end
                        phase_next        = PH_LEN;
                        field_count_next  = 32'd0;
                        chunk_length_next = 32'd0;
                        chunk_start_next  = off_inc;
                    end else begin
                        field_count_next = fc_inc;
                    end
                end
                default: begin
                    phase_next = PH_SIG;
                end
            endcase
        end

        // end of file: report the open state, then rearm for the next file
        if (in_last) begin
            if (!done_next) begin
                if (header_seen_next) begin
                    result = '{fire: 1'b1, verdict: V_PROMISING,
                               size: sat32(64'(chunk_start_next))};
                end else begin
                    result = '{fire: 1'b1, verdict: V_INVALID, size: 32'd0};
                end
            end
            byte_offset_next  = '0;
            phase_next        = PH_SIG;
            field_count_next  = 32'd0;
            chunk_length_next = 32'd0;
            chunk_type_next   = 32'd0;
            chunk_start_next  = START_INIT;
            crc_accum_next    = CRC_PRESET;
            stored_check_next = 32'd0;
            header_seen_next  = 1'b0;
            done_next         = 1'b0;
        end

        if (!in_fire) begin
            result.fire = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg  <= '0;
            phase_reg        <= PH_SIG;
            field_count_reg  <= 32'd0;
            chunk_length_reg <= 32'd0;
            chunk_type_reg   <= 32'd0;
            chunk_start_reg  <= START_INIT;
            crc_accum_reg    <= CRC_PRESET;
            stored_check_reg <= 32'd0;
            header_seen_reg  <= 1'b0;
            done_reg         <= 1'b0;
        end else if (in_fire) begin
            byte_offset_reg  <= byte_offset_next;
            phase_reg        <= phase_next;
            field_count_reg  <= field_count_next;
            chunk_length_reg <= chunk_length_next;
            chunk_type_reg   <= chunk_type_next;
            chunk_start_reg  <= chunk_start_next;
            crc_accum_reg    <= crc_accum_next;
            stored_check_reg <= stored_check_next;
            header_seen_reg  <= header_seen_next;
            done_reg         <= done_next;
        end
    end

endmodule

FILE: verif/png_stream_checker.sv
module png_stream_checker
    import pngcsv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // [1:0] verdict, [33:2] covered_bytes
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] size;
    } file_verdict_t;

    file_verdict_t verdict_q[$];
    int            miss_count = 0;

    // parser shadow
    phase_t      ph;
    logic [31:0] pos;
    logic [31:0] fcnt;
    logic [31:0] clen;
    logic [31:0] ctype;
    logic [31:0] cstart;
    logic [31:0] crc;
    logic [31:0] stored;
    logic        hdr_seen;
    logic        decided;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
    endfunction

    task automatic rearm_parser();
        ph       = PH_SIG;
        pos      = 32'd0;
        fcnt     = 32'd0;
        clen     = 32'd0;
        ctype    = 32'd0;
        cstart   = FIRST_START;
        crc      = 32'hFFFF_FFFF;
        stored   = 32'd0;
        hdr_seen = 1'b0;
        decided  = 1'b0;
    endtask

    task automatic conclude(input verdict_t v, input logic [31:0] size);
        file_verdict_t r;
        r.verdict = v;
        r.size    = (v == V_INVALID) ? 32'd0 : size;
        verdict_q.push_back(r);
        decided = 1'b1;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic lst);
        logic [31:0] end_pos;
        end_pos = 32'd0;
        if (!decided) begin
            case (ph)
                PH_SIG: begin
                    if (fcnt >= 32'd8 || b != SIG_BYTES[fcnt[2:0]]) begin
                        conclude(V_INVALID, 32'd0);
                    end else begin
                        fcnt = fcnt + 32'd1;
                        if (fcnt == 32'd8) begin
                            ph     = PH_LEN;
                            fcnt   = 32'd0;
                            cstart = bump(pos);
                        end
                    end
                end
                PH_LEN: begin
                    clen = {clen[23:0], b};
                    fcnt = fcnt + 32'd1;
                    if (fcnt >= 32'd4) begin
                        ph    = PH_TYPE;
                        fcnt  = 32'd0;
                        crc   = 32'hFFFF_FFFF;
                        ctype = 32'd0;
                    end
                end
                PH_TYPE: begin
                    ctype = {ctype[23:0], b};
                    crc   = crc_step(crc, b);
                    fcnt  = fcnt + 32'd1;
                    if (fcnt >= 32'd4) begin
                        stored = 32'd0;
                        if (clen != 32'd0) begin
                            ph   = PH_DATA;
                            fcnt = clen;
                        end else begin
                            ph   = PH_CRC;
                            fcnt = 32'd0;
                        end
                    end
                end
                PH_DATA: begin
                    crc = crc_step(crc, b);
                    if (fcnt != 32'd0) fcnt = fcnt - 32'd1;
                    if (fcnt == 32'd0) ph = PH_CRC;
                end
                default: begin
                    stored = {stored[23:0], b};
                    fcnt   = fcnt + 32'd1;
                    if (fcnt >= 32'd4) begin
                        end_pos = bump(pos);
                        if (~crc != stored) begin
                            conclude(V_INVALID, 32'd0);
                        end else if (ctype == TYPE_IHDR) begin
                            if (cstart != FIRST_START || clen != IHDR_LEN)
                                conclude(V_INVALID, 32'd0);
                            else
                                hdr_seen = 1'b1;
                        end else if (ctype == TYPE_IEND) begin
                            conclude(hdr_seen ? V_VALIDATES : V_INVALID, end_pos);
                        end
                        ph     = PH_LEN;
                        fcnt   = 32'd0;
                        clen   = 32'd0;
                        cstart = end_pos;
                    end
                end
            endcase
        end
        if (!decided && lst) conclude(hdr_seen ? V_PROMISING : V_INVALID, cstart);
        pos = bump(pos);
        if (lst) rearm_parser();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        miss_count++;
    endtask

    always @(posedge aclk) begin
        file_verdict_t want;
        if (!aresetn) begin
            rearm_parser();
            verdict_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report("result beat with nothing due", 32'(m_tdata[33:0]), 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] != want.verdict)
                        report("verdict", 32'(m_tdata[1:0]), 32'(want.verdict));
                    if (m_tdata[33:2] != want.size)
                        report("covered_bytes", m_tdata[33:2], want.size);
                end
            end
            if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast);
        end
        mismatches <= miss_count;
        pending    <= verdict_q.size();
    end

endmodule

FILE: verif/tb_png_chunk_stream_validator.sv
module tb_png_chunk_stream_validator
    import pngcsv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT   = 1000;
    localparam int          MIN_BYTES     = 1700;
    localparam logic [31:0] CRC32_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] TYPE_IDAT     = 32'h4944_4154;
    localparam logic [31:0] TYPE_TEXT     = 32'h7445_5874;
    localparam int          FILL_RANDOM   = -1;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'd0;   // [7:0] data_byte
    logic               s_tlast  = 1'b0;   // last_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // [1:0] verdict, [33:2] covered_bytes

    int mismatches;
    int pending;

    logic [7:0] file_q[$];
    logic [8:0] beat_q[$];   // {last, data}

    int rx_mode     = 0;
    int rx_hold     = 0;
    int rx_cycle    = 0;
    int idle_cycles = 0;

    always #1 aclk = ~aclk;

    png_chunk_stream_validator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    png_stream_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] pick_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return TYPE_IHDR;
        if (r < 3) return TYPE_IEND;
        if (r < 10) return TYPE_IDAT;
        if (r < 13) return TYPE_TEXT;
        return $urandom();
    endfunction

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic put_sig(input int count);
        for (int i = 0; i < count; i++) file_q.push_back(SIG_BYTES[i]);
    endtask

    task automatic put_chunk(input int unsigned len, input logic [31:0] typ, input bit crc_ok,
                             input int fill);
        logic [31:0] c;
        logic [7:0]  d;
        put_word(len);
        c = 32'hFFFF_FFFF;
        for (int i = 3; i >= 0; i--) begin
            file_q.push_back(typ[8*i +: 8]);
            c = crc_feed(c, typ[8*i +: 8]);
        end
        for (int unsigned i = 0; i < len; i++) begin
            d = (fill == FILL_RANDOM) ? 8'($urandom_range(0, 255)) : 8'(fill);
            file_q.push_back(d);
            c = crc_feed(c, d);
        end
        c = ~c;
        if (!crc_ok) c = c ^ (32'd1 << $urandom_range(0, 31));
        put_word(c);
    endtask

    task automatic emit_file();
        foreach (file_q[i]) beat_q.push_back({i == file_q.size() - 1, file_q[i]});
        file_q.delete();
    endtask

    task automatic build_directed();
        // minimal good file, IHDR data all ones
        put_sig(8); put_chunk(13, TYPE_IHDR, 1, 8'hFF); put_chunk(0, TYPE_IEND, 1, 0); emit_file();
        // good file, zero-length and data chunks, bytes after IEND are ignored
        put_sig(8); put_chunk(13, TYPE_IHDR, 1, 8'h00); put_chunk(0, TYPE_TEXT, 1, 0);
        put_chunk(5, TYPE_IDAT, 1, FILL_RANDOM); put_chunk(0, TYPE_IEND, 1, 0);
        file_q.push_back(8'hFF); file_q.push_back(8'h00); emit_file();
        // bad first byte, single-byte file
        file_q.push_back(8'h00); emit_file();
        // signature breaks mid-way, rest ignored
        put_sig(5); file_q.push_back(8'hFF); put_sig(8); emit_file();
        // file ends inside the signature
        put_sig(3); emit_file();
        // signature only
        put_sig(8); emit_file();
        // IHDR with bad CRC
        put_sig(8); put_chunk(13, TYPE_IHDR, 0, FILL_RANDOM); put_chunk(0, TYPE_IEND, 1, 0);
        emit_file();
        // IHDR with wrong length
        put_sig(8); put_chunk(12, TYPE_IHDR, 1, FILL_RANDOM); put_chunk(0, TYPE_IEND, 1, 0);
        emit_file();
        // IHDR not first
        put_sig(8); put_chunk(2, TYPE_TEXT, 1, FILL_RANDOM); put_chunk(13, TYPE_IHDR, 1, 0);
        put_chunk(0, TYPE_IEND, 1, 0); emit_file();
        // IEND without IHDR
        put_sig(8); put_chunk(0, TYPE_IEND, 1, 0); emit_file();
        // truncated inside a huge chunk
        put_sig(8); put_chunk(13, TYPE_IHDR, 1, FILL_RANDOM); put_word(32'hFFFF_FFFF);
        put_word(TYPE_IDAT); file_q.push_back(8'h5A); emit_file();
        // file ends exactly at the end of IHDR
        put_sig(8); put_chunk(13, TYPE_IHDR, 1, FILL_RANDOM); emit_file();
        // truncated with no IHDR
        put_sig(8); put_chunk(3, TYPE_IDAT, 1, FILL_RANDOM); put_word(32'd7); emit_file();
    endtask

    task automatic make_random_file();
        int kind;
        int n;
        int cut;
        int idx;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            if (kind < 5) put_sig($urandom_range(1, 8));
            n = $urandom_range(1, 24);
            repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            put_sig(8);
            if (kind < 88)
                put_chunk(13, TYPE_IHDR, 1, FILL_RANDOM);
            else if (kind < 94)
                put_chunk($urandom_range(0, 20), TYPE_IHDR, $urandom_range(0, 1) != 0,
                          FILL_RANDOM);
            n = $urandom_range(0, 3);
            repeat (n) put_chunk($urandom_range(0, 16), pick_type(),
                                 $urandom_range(0, 19) != 0, FILL_RANDOM);
            if ($urandom_range(0, 7) != 0) begin
                put_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0, TYPE_IEND,
                          $urandom_range(0, 19) != 0, FILL_RANDOM);
            end else if ($urandom_range(0, 1) != 0) begin
                put_word($urandom());
                n = $urandom_range(0, 8);
                repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
            end
            n = $urandom_range(0, 3);
            repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0: begin
                    idx = $urandom_range(0, file_q.size() - 1);
                    file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(0, 7));
                end
                1: begin
                    cut = $urandom_range(1, file_q.size());
                    while (file_q.size() > cut) void'(file_q.pop_back());
                end
                default: ;
            endcase
        end
        emit_file();
    endtask

    task automatic stream_bytes();
        int         gap;
        int         burst;
        logic [8:0] beat;
        gap   = 0;
        burst = $urandom_range(1, 40);
        while (beat_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
            if (!s_tvalid || s_tready) begin
                if (beat_q.size() != 0 && gap == 0) begin
                    beat = beat_q.pop_front();
                    s_tdata  <= beat[7:0];
                    s_tlast  <= beat[8];
                    s_tvalid <= 1'b1;
                    burst = burst - 1;
                    if (burst == 0) begin
                        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                            : $urandom_range(1, 30);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    if (gap > 0) gap = gap - 1;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 4) == 0) rx_hold <= $urandom_range(1, 20);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("png_chunk_stream_validator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        build_directed();
        while (beat_q.size() < MIN_BYTES) begin
            make_random_file();
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        stream_bytes();
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("png_chunk_stream_validator verification clean");
        else
            $display("png_chunk_stream_validator verification failed");
        $finish;
    end

endmodule
